/* hdl/atbv_pkg.sv */
package atbv_pkg;

	localparam int ANGLE_W             = 16;
	localparam int OUT_W               = 16;
	localparam int FRAC_BITS_DEF       = 14;
	localparam int TABLE_ADDR_BITS_DEF = 10;

endpackage

/* hdl/atbv_sin_rom.sv */
module atbv_sin_rom
	import atbv_pkg::*;
#(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [TABLE_ADDR_BITS:0]   addr_a,
	input  logic [TABLE_ADDR_BITS:0]   addr_b,
	output logic [FRAC_BITS:0]         data_a,
	output logic [FRAC_BITS:0]         data_b
);

	localparam int N  = 1 << TABLE_ADDR_BITS;
	localparam int DW = FRAC_BITS + 1;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef logic [DW-1:0] tbl_t [0:N];

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Taylor term divisor (2k)(2k+1)
	function automatic logic [63:0] div_term(input logic [63:0] v, input int k);
		logic [63:0] r;
		unique case (k)
			1:       r = v / 64'd6;
			2:       r = v / 64'd20;
			3:       r = v / 64'd42;
			4:       r = v / 64'd72;
			5:       r = v / 64'd110;
			6:       r = v / 64'd156;
			7:       r = v / 64'd210;
			8:       r = v / 64'd272;
			9:       r = v / 64'd342;
			10:      r = v / 64'd420;
			11:      r = v / 64'd506;
			12:      r = v / 64'd600;
			13:      r = v / 64'd702;
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic tbl_t build_tbl();
		tbl_t        t;
		logic [63:0] frac;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		for (int i = 0; i <= N; i++) begin
			frac = 64'(i) << (62 - TABLE_ADDR_BITS);
			x    = mul_q62(HALF_PI_Q62, frac);
			x2   = mul_q62(x, x);
			term = x;
			sum  = x;
			for (int k = 1; k <= 13; k++) begin
				term = div_term(mul_q62(term, x2), k);
				if (k % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			t[i] = DW'((sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
		end
		return t;
	endfunction

	localparam tbl_t SINE_TBL = build_tbl();

	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= SINE_TBL[addr_a];
			data_b <= SINE_TBL[addr_b];
		end
	end

endmodule

/* hdl/angles_to_basis_vectors.sv */
// Turns three 16-bit angles (pitch, yaw, roll; 65536 units per turn) into the forward,
// right and up unit vectors of the rotated frame, nine signed components with FRAC_BITS
// fraction bits, clamped to plus or minus one. The block takes one angle beat every
// clock cycle while angle_stall is low and passes it through a six-stage pipeline:
// a registered quarter-wave sine table read (one copy per angle, each with a sine
// and a cosine port), sign fix, first products, rounding, second products, then
// rounding, sums and clamping into the output register. A stall on the vector side
// lets empty stages fill before it reaches angle_stall.
module angles_to_basis_vectors
	import atbv_pkg::*;
#(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               angle_valid,
	output logic               angle_stall,
	input  logic [ANGLE_W-1:0] pitch_angle,
	input  logic [ANGLE_W-1:0] yaw_angle,
	input  logic [ANGLE_W-1:0] roll_angle,
	output logic               basis_valid,
	input  logic               basis_stall,
	output logic [OUT_W-1:0]   forward_x,
	output logic [OUT_W-1:0]   forward_y,
	output logic [OUT_W-1:0]   forward_z,
	output logic [OUT_W-1:0]   right_x,
	output logic [OUT_W-1:0]   right_y,
	output logic [OUT_W-1:0]   right_z,
	output logic [OUT_W-1:0]   up_x,
	output logic [OUT_W-1:0]   up_y,
	output logic [OUT_W-1:0]   up_z
);

	localparam int N  = 1 << TABLE_ADDR_BITS;
	localparam int AW = TABLE_ADDR_BITS + 1;
	localparam int DW = FRAC_BITS + 1;
	localparam int VW = FRAC_BITS + 2;
	localparam int PW = 2 * FRAC_BITS + 4;
	localparam int SW = FRAC_BITS + 3;

	localparam logic [AW-1:0]        TBL_N    = AW'(N);
	localparam logic [PW-1:0]        RND_HALF = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] ONE_S    = SW'(1) << FRAC_BITS;
	localparam logic signed [OUT_W-1:0] ONE_O =
		(FRAC_BITS <= OUT_W - 2) ? OUT_W'(1 << FRAC_BITS) : '0;

	typedef struct packed {
		logic sin_neg;
		logic cos_neg;
	} sign_t;

	typedef struct packed {
		logic [AW-1:0] sin_addr;
		logic [AW-1:0] cos_addr;
		sign_t         sign;
	} lookup_t;

	function automatic lookup_t angle_lookup(input logic [ANGLE_W-1:0] a);
		lookup_t       l;
		logic [1:0]    quad;
		logic [AW-1:0] ix;
		logic [AW-1:0] nx;
		quad = a[ANGLE_W-1 -: 2];
		ix   = {1'b0, a[ANGLE_W-3 -: TABLE_ADDR_BITS]};
		nx   = TBL_N - ix;
		l.sin_addr     = quad[0] ? nx : ix;
		l.cos_addr     = quad[0] ? ix : nx;
		l.sign.sin_neg = quad[1];
		l.sign.cos_neg = quad[1] ^ quad[0];
		return l;
	endfunction

	function automatic logic signed [VW-1:0] apply_sign(input logic [DW-1:0] m, input logic neg);
		logic signed [VW-1:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [VW-1:0] rnd_prod(input logic signed [PW-1:0] p);
		logic [PW-1:0] mag;
		logic [PW-1:0] r;
		mag = p[PW-1] ? (~p + 1'b1) : p;
		r   = (mag + RND_HALF) >> FRAC_BITS;
		return p[PW-1] ? -$signed(r[VW-1:0]) : $signed(r[VW-1:0]);
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

	function automatic logic [OUT_W-1:0] clamp_out(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		if (v > ONE_S) begin
			c = ONE_S;
		end else if (v < -ONE_S) begin
			c = -ONE_S;
		end else begin
			c = v;
		end
		return OUT_W'(c);
	endfunction

	logic en1, en2, en3, en4, en5, en6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	lookup_t lk_p, lk_y, lk_r;

	// stage 1: table magnitudes and signs
	logic [DW-1:0] sp_mag_s1, cp_mag_s1, sy_mag_s1, cy_mag_s1, sr_mag_s1, cr_mag_s1;
	sign_t         sgn_p_s1, sgn_y_s1, sgn_r_s1;

	// stage 2: signed sines and cosines
	logic signed [VW-1:0] sp_s2, cp_s2, sy_s2, cy_s2, sr_s2, cr_s2;

	// stage 3: first products
	logic signed [PW-1:0] srsp_s3, crsp_s3, cpcy_s3, cpsy_s3, srcp_s3;
	logic signed [PW-1:0] crcp_s3, crsy_s3, crcy_s3, srsy_s3, srcy_s3;
	logic signed [VW-1:0] sp_s3, sy_s3, cy_s3;

	// stage 4: rounded first products
	logic signed [VW-1:0] srsp_s4, crsp_s4, cpcy_s4, cpsy_s4, srcp_s4;
	logic signed [VW-1:0] crcp_s4, crsy_s4, crcy_s4, srsy_s4, srcy_s4;
	logic signed [VW-1:0] sp_s4, sy_s4, cy_s4;

	// stage 5: second products
	logic signed [PW-1:0] srspcy_s5, srspsy_s5, crspcy_s5, crspsy_s5;
	logic signed [VW-1:0] cpcy_s5, cpsy_s5, srcp_s5, crcp_s5;
	logic signed [VW-1:0] crsy_s5, crcy_s5, srsy_s5, srcy_s5, sp_s5;

	// stage 6: output register
	logic [OUT_W-1:0] fx_s6, fy_s6, fz_s6, rx_s6, ry_s6, rz_s6, ux_s6, uy_s6, uz_s6;

	assign en6 = !vld_s6 || !basis_stall;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign angle_stall = !en1;
	assign basis_valid = vld_s6;

	assign lk_p = angle_lookup(pitch_angle);
	assign lk_y = angle_lookup(yaw_angle);
	assign lk_r = angle_lookup(roll_angle);

	atbv_sin_rom #(
		.FRAC_BITS       (FRAC_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom_pitch (
		.clk    (clk),
		.en     (en1),
		.addr_a (lk_p.sin_addr),
		.addr_b (lk_p.cos_addr),
		.data_a (sp_mag_s1),
		.data_b (cp_mag_s1)
	);

	atbv_sin_rom #(
		.FRAC_BITS       (FRAC_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom_yaw (
		.clk    (clk),
		.en     (en1),
		.addr_a (lk_y.sin_addr),
		.addr_b (lk_y.cos_addr),
		.data_a (sy_mag_s1),
		.data_b (cy_mag_s1)
	);

	atbv_sin_rom #(
		.FRAC_BITS       (FRAC_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom_roll (
		.clk    (clk),
		.en     (en1),
		.addr_a (lk_r.sin_addr),
		.addr_b (lk_r.cos_addr),
		.data_a (sr_mag_s1),
		.data_b (cr_mag_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= angle_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sgn_p_s1 <= lk_p.sign;
			sgn_y_s1 <= lk_y.sign;
			sgn_r_s1 <= lk_r.sign;
		end
		if (en2) begin
			sp_s2 <= apply_sign(sp_mag_s1, sgn_p_s1.sin_neg);
			cp_s2 <= apply_sign(cp_mag_s1, sgn_p_s1.cos_neg);
			sy_s2 <= apply_sign(sy_mag_s1, sgn_y_s1.sin_neg);
			cy_s2 <= apply_sign(cy_mag_s1, sgn_y_s1.cos_neg);
			sr_s2 <= apply_sign(sr_mag_s1, sgn_r_s1.sin_neg);
			cr_s2 <= apply_sign(cr_mag_s1, sgn_r_s1.cos_neg);
		end
		if (en3) begin
			srsp_s3 <= mul(sr_s2, sp_s2);
			crsp_s3 <= mul(cr_s2, sp_s2);
			cpcy_s3 <= mul(cp_s2, cy_s2);
			cpsy_s3 <= mul(cp_s2, sy_s2);
			srcp_s3 <= mul(sr_s2, cp_s2);
			crcp_s3 <= mul(cr_s2, cp_s2);
			crsy_s3 <= mul(cr_s2, sy_s2);
			crcy_s3 <= mul(cr_s2, cy_s2);
			srsy_s3 <= mul(sr_s2, sy_s2);
			srcy_s3 <= mul(sr_s2, cy_s2);
			sp_s3   <= sp_s2;
			sy_s3   <= sy_s2;
			cy_s3   <= cy_s2;
		end
		if (en4) begin
			srsp_s4 <= rnd_prod(srsp_s3);
			crsp_s4 <= rnd_prod(crsp_s3);
			cpcy_s4 <= rnd_prod(cpcy_s3);
			cpsy_s4 <= rnd_prod(cpsy_s3);
			srcp_s4 <= rnd_prod(srcp_s3);
			crcp_s4 <= rnd_prod(crcp_s3);
			crsy_s4 <= rnd_prod(crsy_s3);
			crcy_s4 <= rnd_prod(crcy_s3);
			srsy_s4 <= rnd_prod(srsy_s3);
			srcy_s4 <= rnd_prod(srcy_s3);
			sp_s4   <= sp_s3;
			sy_s4   <= sy_s3;
			cy_s4   <= cy_s3;
		end
		if (en5) begin
			srspcy_s5 <= mul(srsp_s4, cy_s4);
			srspsy_s5 <= mul(srsp_s4, sy_s4);
			crspcy_s5 <= mul(crsp_s4, cy_s4);
			crspsy_s5 <= mul(crsp_s4, sy_s4);
			cpcy_s5   <= cpcy_s4;
			cpsy_s5   <= cpsy_s4;
			srcp_s5   <= srcp_s4;
			crcp_s5   <= crcp_s4;
			crsy_s5   <= crsy_s4;
			crcy_s5   <= crcy_s4;
			srsy_s5   <= srsy_s4;
			srcy_s5   <= srcy_s4;
			sp_s5     <= sp_s4;
		end
		if (en6) begin
			fx_s6 <= clamp_out(SW'(cpcy_s5));
			fy_s6 <= clamp_out(SW'(cpsy_s5));
			fz_s6 <= clamp_out(SW'(sp_s5));
			rx_s6 <= clamp_out(SW'(rnd_prod(srspcy_s5)) - SW'(crsy_s5));
			ry_s6 <= clamp_out(SW'(rnd_prod(srspsy_s5)) + SW'(crcy_s5));
			rz_s6 <= clamp_out(-SW'(srcp_s5));
			ux_s6 <= clamp_out(-SW'(rnd_prod(crspcy_s5)) - SW'(srsy_s5));
			uy_s6 <= clamp_out(-SW'(rnd_prod(crspsy_s5)) + SW'(srcy_s5));
			uz_s6 <= clamp_out(SW'(crcp_s5));
		end
	end

	assign forward_x = fx_s6;
	assign forward_y = fy_s6;
	assign forward_z = fz_s6;
	assign right_x   = rx_s6;
	assign right_y   = ry_s6;
	assign right_z   = rz_s6;
	assign up_x      = ux_s6;
	assign up_y      = uy_s6;
	assign up_z      = uz_s6;

	a_empty_front_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> !angle_stall)
		else $error("input stalled with first stage empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && !angle_stall |=> vld_s1)
		else $error("accepted beat did not enter the pipeline");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !en5 |=> vld_s5 && $stable(srspcy_s5) && $stable(crsy_s5))
		else $error("stalled stage lost its beat");

	a_output_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && (FRAC_BITS <= OUT_W - 2) |->
			($signed(up_x) <= ONE_O) && ($signed(up_x) >= -ONE_O) &&
			($signed(right_x) <= ONE_O) && ($signed(right_x) >= -ONE_O))
		else $error("component outside plus or minus one");

endmodule

/* sim/angles_to_basis_vectors_test.sv */
`timescale 1ns / 1ps

module angles_to_basis_vectors_test;
	import atbv_pkg::*;

	typedef logic [8:0][OUT_W-1:0] basis_t;

	class frame_predictor;
		localparam int FB    = FRAC_BITS_DEF;
		localparam int TAB   = TABLE_ADDR_BITS_DEF;
		localparam int TBL_N = 1 << TAB;
		localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

		int     sine_q[TBL_N + 1];
		basis_t expected_frames[$];
		string  comp_name[9];
		int     errors;

		function new();
			logic [63:0] frac, x, x2, term, sum;
			comp_name = '{"forward_x", "forward_y", "forward_z", "right_x", "right_y",
				"right_z", "up_x", "up_y", "up_z"};
			errors = 0;
			for (int i = 0; i <= TBL_N; i++) begin
				frac = 64'(i) << (62 - TAB);
				x    = mul_q62(HALF_PI_Q62, frac);
				x2   = mul_q62(x, x);
				term = x;
				sum  = x;
				for (int k = 1; k <= 13; k++) begin
					term = mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
					if (k % 2 == 1) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
				sine_q[i] = int'((sum + (64'd1 << (61 - FB))) >> (62 - FB));
			end
		endfunction

		function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return p[125:62];
		endfunction

		function longint quad_sine(int quad, int idx);
			case (quad & 3)
				0: return sine_q[idx];
				1: return sine_q[TBL_N - idx];
				2: return -sine_q[idx];
				default: return -sine_q[TBL_N - idx];
			endcase
		endfunction

		function void trig(logic [ANGLE_W-1:0] a, output longint s, output longint c);
			int top, quad, idx;
			top  = int'(a) >> (14 - TAB);
			quad = (top >> TAB) & 3;
			idx  = top & (TBL_N - 1);
			s = quad_sine(quad, idx);
			c = quad_sine(quad + 1, idx);
		endfunction

		function longint rmul(longint a, longint b);
			longint p, half;
			p    = a * b;
			half = longint'(1) << (FB - 1);
			if (p < 0) begin
				return -((-p + half) >> FB);
			end
			return (p + half) >> FB;
		endfunction

		function logic [OUT_W-1:0] clamp(longint v);
			longint one;
			one = longint'(1) << FB;
			if (v > one) begin
				v = one;
			end
			if (v < -one) begin
				v = -one;
			end
			return OUT_W'(v);
		endfunction

		function void note_angles(logic [ANGLE_W-1:0] p, logic [ANGLE_W-1:0] y,
				logic [ANGLE_W-1:0] r);
			longint sp, cp, sy, cy, sr, cr, srsp, crsp;
			basis_t f;
			trig(p, sp, cp);
			trig(y, sy, cy);
			trig(r, sr, cr);
			srsp = rmul(sr, sp);
			crsp = rmul(cr, sp);
			f[0] = clamp(rmul(cp, cy));
			f[1] = clamp(rmul(cp, sy));
			f[2] = clamp(sp);
			f[3] = clamp(rmul(srsp, cy) - rmul(cr, sy));
			f[4] = clamp(rmul(srsp, sy) + rmul(cr, cy));
			f[5] = clamp(-rmul(sr, cp));
			f[6] = clamp(-rmul(crsp, cy) - rmul(sr, sy));
			f[7] = clamp(-rmul(crsp, sy) + rmul(sr, cy));
			f[8] = clamp(rmul(cr, cp));
			expected_frames.push_back(f);
		endfunction

		function void check_basis(basis_t got);
			basis_t want;
			if (expected_frames.size() == 0) begin
				$display("%0t: vector beat with nothing expected", $time);
				errors++;
				return;
			end
			want = expected_frames.pop_front();
			for (int i = 0; i < 9; i++) begin
				if (got[i] !== want[i]) begin
					$display("%0t: %s expected %0d got %0d", $time, comp_name[i],
						$signed(want[i]), $signed(got[i]));
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               angle_valid = 1'b0;
	logic               angle_stall;
	logic [ANGLE_W-1:0] pitch_angle = '0;
	logic [ANGLE_W-1:0] yaw_angle   = '0;
	logic [ANGLE_W-1:0] roll_angle  = '0;
	logic               basis_valid;
	logic               basis_stall = 1'b0;
	logic [OUT_W-1:0]   forward_x, forward_y, forward_z;
	logic [OUT_W-1:0]   right_x, right_y, right_z;
	logic [OUT_W-1:0]   up_x, up_y, up_z;

	frame_predictor frames = new();
	bit             calm   = 1'b0;
	int             stall_left = 0;

	angles_to_basis_vectors u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.roll_angle  (roll_angle),
		.basis_valid (basis_valid),
		.basis_stall (basis_stall),
		.forward_x   (forward_x),
		.forward_y   (forward_y),
		.forward_z   (forward_z),
		.right_x     (right_x),
		.right_y     (right_y),
		.right_z     (right_z),
		.up_x        (up_x),
		.up_y        (up_y),
		.up_z        (up_z)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ANGLE_W-1:0] pick_angle(int kind);
		logic [ANGLE_W-1:0] quad_base;
		quad_base = ANGLE_W'($urandom_range(0, 3)) << 14;
		case (kind)
			6, 7: return quad_base + ANGLE_W'($urandom_range(0, 63)) - ANGLE_W'(32);
			8: begin
				case ($urandom_range(0, 4))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'h4000;
					3: return 16'h8000;
					default: return 16'hC000;
				endcase
			end
			default: return ANGLE_W'($urandom());
		endcase
	endfunction

	task automatic send_angles(logic [ANGLE_W-1:0] p, logic [ANGLE_W-1:0] y,
			logic [ANGLE_W-1:0] r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			angle_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		angle_valid <= 1'b1;
		pitch_angle <= p;
		yaw_angle   <= y;
		roll_angle  <= r;
		do @(posedge clk); while (angle_stall);
		frames.note_angles(p, y, r);
	endtask

	task automatic wait_drained();
		angle_valid <= 1'b0;
		for (int n = 0; n < 5000 && frames.pending() != 0; n++) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && basis_valid && !basis_stall) begin
			frames.check_basis({up_z, up_y, up_x, right_z, right_y, right_x,
				forward_z, forward_y, forward_x});
		end
		if (stall_left > 0) begin
			stall_left--;
			basis_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(7, 39);
			basis_stall <= 1'b1;
		end else begin
			basis_stall <= 1'b0;
		end
	end

	initial begin
		int kind;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_angles(16'h0000, 16'h0000, 16'h0000);
		send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_angles(16'h4000, 16'h0000, 16'h0000);
		send_angles(16'hC000, 16'h0000, 16'h0000);
		send_angles(16'h8000, 16'h8000, 16'h8000);
		send_angles(16'h0000, 16'h4000, 16'h0000);
		send_angles(16'h0000, 16'h0000, 16'h4000);
		send_angles(16'h0000, 16'hC000, 16'hC000);
		send_angles(16'h000F, 16'h000F, 16'h000F);
		send_angles(16'h0010, 16'h0010, 16'h0010);
		send_angles(16'h3FFF, 16'h7FFF, 16'hBFFF);
		send_angles(16'h4010, 16'h8010, 16'hC010);
		send_angles(16'h2000, 16'h2000, 16'h2000);
		send_angles(16'hE000, 16'h6000, 16'hA000);
		send_angles(16'h5555, 16'hAAAA, 16'h5555);
		send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
		send_angles(16'h4000, 16'h4000, 16'h4000);
		send_angles(16'hC000, 16'hC000, 16'h4000);
		send_angles(16'h1234, 16'hFEDC, 16'h8001);
		send_angles(16'h7FF0, 16'h0000, 16'hFFF0);

		for (int n = 0; n < 1050; n++) begin
			if (n == 300) begin
				calm <= 1'b1;
			end
			if (n == 450) begin
				calm <= 1'b0;
			end
			if (n == 600) begin
				wait_drained();
			end
			kind = $urandom_range(0, 9);
			send_angles(pick_angle(kind), pick_angle(kind), pick_angle(kind));
		end

		wait_drained();
		if (frames.pending() != 0) begin
			$display("%0t: %0d vector beats never arrived", $time, frames.pending());
			frames.errors += frames.pending();
		end
		repeat (20) @(posedge clk);
		if (frames.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
